FILE: hdl/dss_pkg.sv
// Types and constants for the delimiter string splitter.
package dss_pkg;

   localparam int DELIM_MAX_DEFAULT = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_BYTES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_LEN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_EMPTY  = 2'd2;

   localparam logic [63:0] DELIM_BYTES_RESET = 64'd44;
   localparam logic [3:0]  DELIM_LEN_RESET   = 4'd1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_kind;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic       shift;
      logic       write;
      logic [7:0] new_byte;
   } cell_ctl_type;

endpackage

FILE: hdl/delimiter_string_splitter.sv
// Top level of the delimiter string splitter: window cell chain, control and CSRs.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    req_payload  (req_type)
//   rsp_      out        rsp_valid/rsp_ready    rsp_payload  (rsp_type)
//   csr_      in         csr_wr_en              csr_index, csr_wr_data
//
// One request is taken per cycle while it causes at most one result; the
// window cells compare all delimiter bytes in parallel in that cycle.
// A request marked end_of_string starts a flush that sends each byte left in the
// window and then an end of token if a token is open; a request that meets a
// shortened delimiter is taken at once and held while surplus window bytes drain.
// Reset is synchronous and clears control state; window bytes are not cleared.
// Results wait in a two-entry buffer, so a stalled rsp_ready holds back
// req_ready only once both entries are full.
module delimiter_string_splitter import dss_pkg::*; #(
   parameter int DELIM_MAX = DELIM_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int FILL_W  = $clog2(DELIM_MAX + 1);
   localparam int DBITS_W = DELIM_MAX * 8;

   logic [DBITS_W-1:0] delim_bytes_ff;
   logic [3:0]         delim_len_ff;
   logic               keep_empty_ff;

   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic               started_ff;
   logic               started_in;
   logic               flush_ff;
   logic               flush_in;
   logic               pend_ff;
   logic               pend_in;
   req_type            pend_req_ff;
   req_type            pend_req_in;

   logic [3:0]         len_sat;
   logic [FILL_W-1:0]  len_eff;
   logic               fill_ge_len;
   logic               hit;
   logic               all_match;
   logic               space;
   logic               do_flush;
   logic               do_drain;
   logic               do_step;
   logic               acc;
   logic               push;
   rsp_type            push_data;
   req_type            cur;
   cell_ctl_type       ctl;

   logic [7:0]           taps [DELIM_MAX];
   logic [DELIM_MAX-1:0] eqs;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff <= DBITS_W'(DELIM_BYTES_RESET);
         delim_len_ff   <= DELIM_LEN_RESET;
         keep_empty_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELIM_BYTES: delim_bytes_ff <= csr_wr_data[DBITS_W-1:0];
            CSR_DELIM_LEN:   delim_len_ff   <= csr_wr_data[3:0];
            CSR_KEEP_EMPTY:  keep_empty_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (delim_len_ff == 4'd0) begin
         len_sat = 4'd1;
      end else if (delim_len_ff > 4'(DELIM_MAX)) begin
         len_sat = 4'(DELIM_MAX);
      end else begin
         len_sat = delim_len_ff;
      end
   end
   assign len_eff = len_sat[FILL_W-1:0];

   assign fill_ge_len = (fill_ff >= len_eff);
   assign hit         = (({1'b0, fill_ff} + (FILL_W+1)'(1)) == {1'b0, len_eff});
   assign all_match   = &eqs;

   // A request that finds surplus window bytes is held until they have left.
   assign req_ready = !flush_ff && !pend_ff && space;
   assign acc       = req_valid && req_ready;
   assign cur       = pend_ff ? pend_req_ff : req_payload;
   assign do_flush  = flush_ff && space;
   assign do_drain  = (acc || (pend_ff && space)) && fill_ge_len;
   assign do_step   = (acc || (pend_ff && space)) && !fill_ge_len;

   always_comb begin
      fill_in      = fill_ff;
      started_in   = started_ff;
      flush_in     = flush_ff;
      pend_in      = pend_ff;
      pend_req_in  = pend_req_ff;
      push         = 1'b0;
      push_data    = '0;
      ctl.shift    = 1'b0;
      ctl.write    = do_step;
      ctl.new_byte = cur.in_byte;

      if (do_flush) begin
         if (fill_ff != '0) begin
            push               = 1'b1;
            push_data.out_byte = taps[0];
            push_data.out_kind = KIND_BYTE;
            ctl.shift          = 1'b1;
            fill_in            = fill_ff - FILL_W'(1);
            started_in         = 1'b1;
         end else begin
            push               = started_ff;
            push_data.out_kind = KIND_END;
            push_data.run_last = 1'b1;
            started_in         = 1'b0;
            flush_in           = 1'b0;
         end
      end else if (do_drain) begin
         push               = 1'b1;
         push_data.out_byte = taps[0];
         push_data.out_kind = KIND_BYTE;
         ctl.shift          = 1'b1;
         fill_in            = fill_ff - FILL_W'(1);
         started_in         = 1'b1;
         pend_in            = 1'b1;
         pend_req_in        = cur;
      end else if (do_step) begin
         pend_in = 1'b0;
         if (hit && all_match) begin
            push               = started_ff || keep_empty_ff;
            push_data.out_kind = KIND_END;
            push_data.run_last = 1'b1;
            fill_in            = '0;
            started_in         = 1'b0;
         end else if (hit) begin
            // A full window that misses sends its oldest byte on.
            push               = 1'b1;
            push_data.out_byte = taps[0];
            push_data.out_kind = KIND_BYTE;
            push_data.run_last = !cur.end_of_string;
            ctl.shift          = 1'b1;
            started_in         = 1'b1;
            flush_in           = cur.end_of_string;
         end else begin
            fill_in  = fill_ff + FILL_W'(1);
            flush_in = cur.end_of_string;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         started_ff <= 1'b0;
         flush_ff   <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         started_ff <= started_in;
         flush_ff   <= flush_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_req_ff <= pend_req_in;
   end

   for (genvar k = 0; k < DELIM_MAX; k++) begin : g_cell
      logic [7:0] nbr;
      if (k == DELIM_MAX - 1) begin : g_end
         assign nbr = 8'h00;
      end else begin : g_mid
         assign nbr = taps[k+1];
      end

      dss_cell u_cell (
         .clock  (clock),
         .ctl    (ctl),
         .sel    (do_step && (fill_ff == FILL_W'(k))),
         .active (FILL_W'(k) < len_eff),
         .delim  (delim_bytes_ff[8*k +: 8]),
         .nbr    (nbr),
         .tap    (taps[k]),
         .eq     (eqs[k])
      );
   end

   dss_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/dss_cell.sv
// One byte cell of the delimiter window, with its own delimiter compare.
module dss_cell import dss_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         sel,
   input  logic         active,
   input  logic [7:0]   delim,
   input  logic [7:0]   nbr,
   output logic [7:0]   tap,
   output logic         eq
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // The incoming byte is seen here in the same cycle it is written.
   assign tap = sel ? ctl.new_byte : data_ff;
   assign eq  = !active || (tap == delim);

   always_comb begin
      if (ctl.shift) begin
         data_in = nbr;
      end else if (ctl.write) begin
         data_in = tap;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: hdl/dss_skid.sv
// Two-entry result buffer between the splitter core and the result channel.
module dss_skid import dss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   rsp_type    q0_ff;
   rsp_type    q1_ff;
   logic [1:0] cnt_ff;
   logic       pop;

   assign pop         = rsp_valid && rsp_ready;
   assign space       = (cnt_ff != 2'd2);
   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = q0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push && !pop) begin
         cnt_ff <= cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (cnt_ff == 2'd1) begin
            q0_ff <= push_data;
         end else begin
            q0_ff <= q1_ff;
            q1_ff <= push_data;
         end
      end else if (pop) begin
         q0_ff <= q1_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            q0_ff <= push_data;
         end else begin
            q1_ff <= push_data;
         end
      end
   end

endmodule

FILE: hdl/dss_checker.sv
// Port-level checks for the delimiter string splitter, bound to the top level.
module dss_checker import dss_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A stalled result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset empties the result buffer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An end of token carries no byte.
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_kind == KIND_END |-> rsp_payload.out_byte == 8'h00)
      else $error("end of token with nonzero byte");

   // Nothing follows an end of token within the same request.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_kind == KIND_END |-> rsp_payload.run_last)
      else $error("end of token not last of its request");

endmodule

bind delimiter_string_splitter dss_checker u_dss_checker (.*);

FILE: test/dss_token_checker.sv
// Token checker for the delimiter string splitter: predicts every result and compares it.
`timescale 1ns / 1ps

module dss_token_checker import dss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     fail_count,
   output int                     expected_left
);

   logic [63:0] delim_word;
   logic [3:0]  delim_count;
   logic        keep_blank;

   logic [7:0]  held [0:7];
   int unsigned held_count;
   bit          token_open;

   rsp_type     piece_q[$];
   rsp_type     token_q[$];
   int          fails;

   function automatic int unsigned live_len();
      int unsigned len;
      len = delim_count;
      if (len == 0) len = 1;
      if (len > 8) len = 8;
      return len;
   endfunction

   task push_piece(input logic [7:0] b, input logic kind);
      rsp_type p;
      p.out_byte = b;
      p.out_kind = kind;
      p.run_last = 1'b0;
      piece_q = {piece_q, p};
   endtask

   task emit_oldest();
      int k;
      push_piece(held[0], KIND_BYTE);
      for (k = 1; k < 8; k++) held[k-1] = held[k];
      held[7] = 8'h00;
      if (held_count > 0) held_count--;
      token_open = 1'b1;
   endtask

   task clear_window();
      int k;
      for (k = 0; k < 8; k++) held[k] = 8'h00;
      held_count = 0;
      token_open = 1'b0;
   endtask

   // Works out every result that one accepted request causes and queues them.
   task split_request(input req_type r);
      int unsigned len;
      int          k;
      bit          hit;
      rsp_type     p;
      len = live_len();
      piece_q.delete();
      // A shortened delimiter drains surplus window bytes before the new byte enters.
      while (held_count >= len && held_count > 0) emit_oldest();
      held[held_count % 8] = r.in_byte;
      held_count++;
      if (held_count == len) begin
         hit = 1'b1;
         for (k = 0; k < len; k++) begin
            if (held[k] != delim_word[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            if (token_open || keep_blank) push_piece(8'h00, KIND_END);
            clear_window();
         end else begin
            emit_oldest();
         end
      end
      if (r.end_of_string) begin
         while (held_count > 0) emit_oldest();
         if (token_open) push_piece(8'h00, KIND_END);
         clear_window();
      end
      for (k = 0; k < piece_q.size(); k++) begin
         p = piece_q[k];
         p.run_last = (k == piece_q.size() - 1);
         token_q = {token_q, p};
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         delim_word  = DELIM_BYTES_RESET;
         delim_count = DELIM_LEN_RESET;
         keep_blank  = 1'b0;
         clear_window();
         token_q.delete();
         fails = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DELIM_BYTES: delim_word = csr_wr_data;
               CSR_DELIM_LEN:   delim_count = csr_wr_data[3:0];
               CSR_KEEP_EMPTY:  keep_blank = csr_wr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) split_request(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               $display("%0t: unexpected result byte %0h kind %0b last %0b", $time,
                        rsp_payload.out_byte, rsp_payload.out_kind, rsp_payload.run_last);
               fails++;
            end else begin
               want = token_q.pop_front();
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %0h actual %0h", $time,
                           want.out_byte, rsp_payload.out_byte);
                  fails++;
               end
               if (rsp_payload.out_kind !== want.out_kind) begin
                  $display("%0t: out_kind expected %0b actual %0b", $time,
                           want.out_kind, rsp_payload.out_kind);
                  fails++;
               end
               if (rsp_payload.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %0b actual %0b", $time,
                           want.run_last, rsp_payload.run_last);
                  fails++;
               end
            end
         end
      end
      fail_count    <= fails;
      expected_left <= token_q.size();
   end

endmodule

FILE: test/tb_delimiter_string_splitter.sv
// Testbench top for the delimiter string splitter: stimulus, handshake timing and verdict.
`timescale 1ns / 1ps

module tb_delimiter_string_splitter;
   import dss_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 16;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DELIM_BYTES;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   int fail_count;
   int expected_left;
   int quiet_cycles = 0;
   bit req_calm = 1'b0;

   always #4 clock = ~clock;

   delimiter_string_splitter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   dss_token_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   // Valid stays high after an accept so that back-to-back requests need no toggle.
   task send_byte(input logic [7:0] b, input logic eos);
      int      gap;
      req_type r;
      gap = req_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.in_byte       = b;
      r.end_of_string = eos;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task configure(input logic [63:0] delim, input logic [3:0] len, input logic keep);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_DELIM_BYTES;
      csr_wr_data <= delim;
      @(posedge clock);
      csr_index   <= CSR_DELIM_LEN;
      csr_wr_data <= {60'd0, len};
      @(posedge clock);
      csr_index   <= CSR_KEEP_EMPTY;
      csr_wr_data <= {63'd0, keep};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] pick_byte(input logic [63:0] delim, input int len);
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return delim[8*$urandom_range(0, len - 1) +: 8];
   endfunction

   // Response side: random stalls, with calm stretches where ready stays high.
   initial begin
      int stall;
      int burst_left;
      bit rsp_calm;
      burst_left = 0;
      rsp_calm   = 1'b0;
      forever begin
         if (burst_left == 0) begin
            rsp_calm   = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(5, 30);
         end
         burst_left--;
         stall = rsp_calm ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] delim;
      logic [3:0]  len;
      logic        keep;
      int          eff;
      int          phase;
      int          sent;
      int          text_len;
      int          cut;
      int          i;
      int          j;
      bit          last;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: comma delimiter, empty tokens dropped, trailing delimiter.
      send_byte(8'h00, 1'b0);
      send_byte(8'h2C, 1'b0);
      send_byte(8'h2C, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h2C, 1'b1);
      settle();

      // Length zero acts as one; empty tokens kept; unused delimiter bytes are junk.
      configure(64'hA5A5_A5A5_A5A5_A52C, 4'd0, 1'b1);
      send_byte(8'h2C, 1'b0);
      send_byte(8'h2C, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'h2C, 1'b1);
      settle();

      // Oversized length acts as the full eight bytes; then a partial match is left held.
      configure(64'h0807_0605_0403_0201, 4'd15, 1'b1);
      for (i = 1; i <= 8; i++) send_byte(i[7:0], 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      settle();

      // Shrinking the delimiter while bytes are held drains the surplus first.
      configure(64'h0807_0605_0403_0201, 4'd2, 1'b0);
      send_byte(8'hAA, 1'b1);
      settle();

      for (phase = 0; phase < 8; phase++) begin
         delim = {$urandom, $urandom};
         len   = 4'($urandom_range(0, 15));
         keep  = 1'($urandom_range(0, 1));
         case (phase)
            0: begin
               delim = 64'h0;
               len   = 4'd1;
            end
            1: begin
               delim = '1;
               len   = 4'd8;
            end
            2: len = 4'd1;
            3: len = 4'd15;
            default: ;
         endcase
         configure(delim, len, keep);
         eff  = (len == 0) ? 1 : (len > 8) ? 8 : len;
         sent = 0;
         while (sent < 15) begin
            req_calm = ($urandom_range(0, 3) == 0);
            text_len = $urandom_range(1, 20);
            for (i = 0; i < text_len; i++) begin
               // Most strings end properly; a few stay open across the next setting.
               last = (i == text_len - 1) && ($urandom_range(0, 9) != 0);
               if ($urandom_range(0, 3) == 0 && !last) begin
                  cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff) : eff;
                  for (j = 0; j < cut; j++) send_byte(delim[8*j +: 8], 1'b0);
                  sent += cut;
               end else begin
                  send_byte(pick_byte(delim, eff), last);
                  sent++;
               end
            end
         end
         req_calm = 1'b0;
         settle();
      end

      if (fail_count == 0 && expected_left == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
